// File: hdl/hrlp_pkg.sv
`timescale 1ns / 1ps

package hrlp_pkg;

    localparam logic [1:0] KIND_WRITE_ACK = 2'd0;
    localparam logic [1:0] KIND_READ_RESP = 2'd1;
    localparam logic [1:0] KIND_INVALID   = 2'd2;
    localparam logic [1:0] KIND_NO_LINE   = 2'd3;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;

    localparam logic [3:0] HEADER_CHARS    = 4'd8;
    localparam logic [7:0] READ_LINE_CHARS = 8'd21;
    localparam logic [7:0] DIGIT_START     = 8'd2;
    localparam logic [7:0] PREFIX_END      = 8'd5;
    localparam logic [7:0] ADDRESS_END     = 8'd13;
    localparam logic [7:0] LINE_MAX        = 8'd255;
    localparam logic [4:0] HEX_NONE        = 5'd16;

    typedef struct packed {
        logic [1:0]  kind;
        logic        header_ok;
        logic [11:0] prefix;
        logic [31:0] address;
        logic [31:0] data;
        logic [7:0]  line_chars;
        logic        is_end;
    } t_result;

    // Expected header text "success\n", one character per position
    function automatic logic [7:0] ok_text(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0:    c = 8'h73;
            3'd1:    c = 8'h75;
            3'd2:    c = 8'h63;
            3'd3:    c = 8'h63;
            3'd4:    c = 8'h65;
            3'd5:    c = 8'h73;
            3'd6:    c = 8'h73;
            default: c = 8'h0A;
        endcase
        return c;
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        priority if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
        else v = HEX_NONE;
        return v;
    endfunction

endpackage

// File: hdl/hrlp_front.sv
`timescale 1ns / 1ps

module hrlp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_ch,
    input  logic               i_full,
    output logic               o_push,
    output hrlp_pkg::t_result  o_rec
);

    logic [3:0]  r_header_pos, n_header_pos;
    logic        r_header_match, n_header_match;
    logic [7:0]  r_line_count, n_line_count;
    logic        r_bad_digit, n_bad_digit;
    logic [11:0] r_prefix_acc, n_prefix_acc;
    logic [31:0] r_address_acc, n_address_acc;
    logic [31:0] r_data_acc, n_data_acc;
    logic        r_listing_done, n_listing_done;

    logic        accept;
    logic [1:0]  line_class;
    logic [4:0]  hex_v;
    logic [3:0]  digit;

    assign accept = i_valid && !i_full;
    assign hex_v  = hrlp_pkg::hex_value(i_ch);
    assign digit  = (hex_v == hrlp_pkg::HEX_NONE) ? 4'd0 : hex_v[3:0];

    always_comb begin
        priority if (r_line_count == 8'd1) line_class = hrlp_pkg::KIND_WRITE_ACK;
        else if (r_line_count == hrlp_pkg::READ_LINE_CHARS && !r_bad_digit)
            line_class = hrlp_pkg::KIND_READ_RESP;
        else line_class = hrlp_pkg::KIND_INVALID;
    end

    always_comb begin
        n_header_pos   = r_header_pos;
        n_header_match = r_header_match;
        n_line_count   = r_line_count;
        n_bad_digit    = r_bad_digit;
        n_prefix_acc   = r_prefix_acc;
        n_address_acc  = r_address_acc;
        n_data_acc     = r_data_acc;
        n_listing_done = r_listing_done;
        o_push           = 1'b0;
        o_rec.kind       = hrlp_pkg::KIND_NO_LINE;
        o_rec.header_ok  = r_header_match && (r_header_pos == hrlp_pkg::HEADER_CHARS);
        o_rec.prefix     = r_prefix_acc;
        o_rec.address    = r_address_acc;
        o_rec.data       = r_data_acc;
        o_rec.line_chars = r_line_count;
        o_rec.is_end     = 1'b0;

        if (accept) begin
            if (r_header_pos < hrlp_pkg::HEADER_CHARS) begin
                if (i_ch == hrlp_pkg::CH_NUL) begin
                    o_push          = 1'b1;
                    o_rec.header_ok = 1'b0;
                    o_rec.is_end    = 1'b1;
                end else begin
                    if (i_ch != hrlp_pkg::ok_text(r_header_pos[2:0]))
                        n_header_match = 1'b0;
                    n_header_pos = r_header_pos + 4'd1;
                end
            end else if (i_ch == hrlp_pkg::CH_NUL) begin
                o_push       = 1'b1;
                o_rec.is_end = 1'b1;
                if (!r_listing_done && r_line_count != 8'd0) o_rec.kind = line_class;
            end else if (!r_listing_done) begin
                if (i_ch == hrlp_pkg::CH_LF) begin
                    if (r_line_count == 8'd0) begin
                        n_listing_done = 1'b1;
                    end else begin
                        o_push        = 1'b1;
                        o_rec.kind    = line_class;
                        n_line_count  = 8'd0;
                        n_bad_digit   = 1'b0;
                        n_prefix_acc  = 12'd0;
                        n_address_acc = 32'd0;
                        n_data_acc    = 32'd0;
                    end
                end else begin
                    if (r_line_count >= hrlp_pkg::DIGIT_START &&
                        r_line_count < hrlp_pkg::READ_LINE_CHARS) begin
                        if (hex_v == hrlp_pkg::HEX_NONE) n_bad_digit = 1'b1;
                        priority if (r_line_count < hrlp_pkg::PREFIX_END)
                            n_prefix_acc = {r_prefix_acc[7:0], digit};
                        else if (r_line_count < hrlp_pkg::ADDRESS_END)
                            n_address_acc = {r_address_acc[27:0], digit};
                        else
                            n_data_acc = {r_data_acc[27:0], digit};
                    end
                    if (r_line_count != hrlp_pkg::LINE_MAX)
                        n_line_count = r_line_count + 8'd1;
                end
            end

            // NUL ends the response: start over from reset values
            if (i_ch == hrlp_pkg::CH_NUL) begin
                n_header_pos   = 4'd0;
                n_header_match = 1'b1;
                n_listing_done = 1'b0;
                n_line_count   = 8'd0;
                n_bad_digit    = 1'b0;
                n_prefix_acc   = 12'd0;
                n_address_acc  = 32'd0;
                n_data_acc     = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_pos   <= 4'd0;
            r_header_match <= 1'b1;
            r_line_count   <= 8'd0;
            r_bad_digit    <= 1'b0;
            r_prefix_acc   <= 12'd0;
            r_address_acc  <= 32'd0;
            r_data_acc     <= 32'd0;
            r_listing_done <= 1'b0;
        end else begin
            r_header_pos   <= n_header_pos;
            r_header_match <= n_header_match;
            r_line_count   <= n_line_count;
            r_bad_digit    <= n_bad_digit;
            r_prefix_acc   <= n_prefix_acc;
            r_address_acc  <= n_address_acc;
            r_data_acc     <= n_data_acc;
            r_listing_done <= n_listing_done;
        end
    end

endmodule

// File: hdl/hrlp_fifo.sv
`timescale 1ns / 1ps

module hrlp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hrlp_pkg::t_result  i_rec,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_nonempty,
    output hrlp_pkg::t_result  o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    hrlp_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_nonempty = (r_count != CW'(0));
    assign o_head     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            if (i_push && !i_pop) r_count <= r_count + CW'(1);
            else if (!i_push && i_pop) r_count <= r_count - CW'(1);
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count above depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_nonempty)
        else $error("pop from empty queue");
`endif

endmodule

// File: hdl/hrlp_back.sv
`timescale 1ns / 1ps

module hrlp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_nonempty,
    input  hrlp_pkg::t_result  i_head,
    output logic               o_pop,
    input  logic               i_stall,
    output logic               o_valid,
    output hrlp_pkg::t_result  o_res
);

    logic              r_valid;
    hrlp_pkg::t_result r_res;
    hrlp_pkg::t_result n_res;

    // Load a new beat when the output is empty or being taken
    assign o_pop = i_nonempty && (!r_valid || !i_stall);

    always_comb begin
        n_res = i_head;
        if (i_head.kind != hrlp_pkg::KIND_READ_RESP) begin
            n_res.prefix  = 12'd0;
            n_res.address = 32'd0;
            n_res.data    = 32'd0;
        end
        if (i_head.kind == hrlp_pkg::KIND_NO_LINE) n_res.line_chars = 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: hdl/hex_response_line_parser.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_ch
// result    out        o_valid / i_stall  o_line_kind .. o_is_end
//
// One character per cycle is accepted while the result queue has room.
// A result is pushed into the result queue on its terminating character and then loaded into the output register.
// Synchronous active-low reset returns the parser to the start of a response.
// o_stall rises only when QUEUE_DEPTH results wait behind a stalled output.
module hex_response_line_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_line_kind,
    output logic        o_header_ok,
    output logic [11:0] o_frame_prefix,
    output logic [31:0] o_frame_address,
    output logic [31:0] o_frame_data,
    output logic [7:0]  o_line_chars,
    output logic        o_is_end
);

    logic              full;
    logic              push;
    logic              pop;
    logic              nonempty;
    hrlp_pkg::t_result rec;
    hrlp_pkg::t_result head;
    hrlp_pkg::t_result res;

    assign o_stall = full;

    hrlp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ch    (i_ch),
        .i_full  (full),
        .o_push  (push),
        .o_rec   (rec)
    );

    hrlp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec      (rec),
        .i_pop      (pop),
        .o_full     (full),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    hrlp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_nonempty (nonempty),
        .i_head     (head),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_res      (res)
    );

    assign o_line_kind     = res.kind;
    assign o_header_ok     = res.header_ok;
    assign o_frame_prefix  = res.prefix;
    assign o_frame_address = res.address;
    assign o_frame_data    = res.data;
    assign o_line_chars    = res.line_chars;
    assign o_is_end        = res.is_end;

endmodule
